[design/pbe_pkg.sv]
`timescale 1ns / 1ps

package pbe_pkg;

  localparam int PADS    = 4;
  localparam int BUTTONS = 21;

  localparam int SLOT_W    = 2;
  localparam int PAD_IDX_W = (PADS > 1) ? $clog2(PADS) : 1;
  localparam int BTN_IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int MAP_W     = 3 * BUTTONS;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 63;

  // Operation codes of an input word.
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_CONNECT = 2'd1;
  localparam logic [1:0] OP_REMOVE  = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  // Direction codes, which are also the prev/next action codes.
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_PREV = 2'd1;
  localparam logic [1:0] DIR_NEXT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ACTION_MAP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd3;

  localparam logic [MAP_W-1:0] ACTION_MAP_RST      = 63'd34239210848611;
  localparam logic [14:0]      DEADZONE_RST        = 15'd16384;
  localparam logic [31:0]      INITIAL_DELAY_RST   = 32'd350000;
  localparam logic [31:0]      REPEAT_INTERVAL_RST = 32'd50000;

  typedef struct packed {
    logic [1:0]         operation;
    logic [SLOT_W-1:0]  pad_slot;
    logic [20:0]        buttons;
    logic signed [15:0] stick_y;
    logic [19:0]        tick_time;
  } pbe_in_t;

  typedef struct packed {
    logic [2:0] action;
    logic       last;
  } pbe_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic emit_tick;
  } pbe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       slot_ok;
    logic       mask_empty;
    logic       fire;
    logic       out_free;
  } pbe_sts_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_TOUT = 4'b1000
  } pbe_state_t;

  function automatic logic [2:0] code_of(input logic [MAP_W-1:0] map,
                                         input int unsigned b);
    return map[3*b +: 3];
  endfunction

endpackage

[design/pbe_ctrl.sv]
`timescale 1ns / 1ps

module pbe_ctrl import pbe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pbe_sts_t sts,
  output pbe_cmd_t cmd
);

  pbe_state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.op == OP_TICK) begin
          state_nxt = S_TOUT;
        end else if (sts.op == OP_SAMPLE && sts.slot_ok) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.mask_empty) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_TOUT: begin
        if (!sts.fire) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_tick = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/pbe_dp.sv]
`timescale 1ns / 1ps

module pbe_dp import pbe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pbe_in_t              in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  pbe_cmd_t             cmd,
  output pbe_sts_t             sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pbe_out_t             out_data
);

  logic [MAP_W-1:0] action_map_r;
  logic [14:0]      deadzone_r;
  logic [31:0]      initial_delay_r;
  logic [31:0]      repeat_interval_r;

  pbe_in_t              in_r;
  logic [BUTTONS-1:0]   pressed_r [PADS];
  logic [BUTTONS-1:0]   mask_r;
  logic [BTN_IDX_W-1:0] idx_r;
  logic [1:0]           tick_dir_r;
  logic [1:0]           hold_dir_r;
  logic [31:0]          held_time_r;
  logic                 repeating_r;
  logic                 fire_r;
  logic [1:0]           fire_dir_r;
  logic                 out_valid_r;
  pbe_out_t             out_r;

  logic [PAD_IDX_W-1:0] pad;
  logic                 slot_ok;
  logic [BUTTONS-1:0]   levels;
  logic [BUTTONS-1:0]   rising;
  logic [BUTTONS-1:0]   emit_mask;
  logic [1:0]           btn_dir;
  logic [1:0]           sample_dir;
  logic signed [16:0]   y_ext;
  logic signed [16:0]   dz_pos;
  logic [32:0]          time_sum;
  logic [31:0]          time_sat;
  logic                 out_free;
  logic                 cur_bit;
  logic [BUTTONS-1:0]   above;
  logic [2:0]           code_cur;

  assign pad     = in_r.pad_slot[PAD_IDX_W-1:0];
  assign slot_ok = (32'(in_r.pad_slot) < 32'(PADS));
  assign levels  = in_r.buttons[BUTTONS-1:0];
  assign rising  = levels & ~pressed_r[pad];

  // Buttons mapped to prev/next steer the direction; those mapped above next emit on a press.
  always_comb begin
    logic [2:0] code_b;
    emit_mask = '0;
    btn_dir   = DIR_NONE;
    code_b    = 3'd0;
    for (int b = BUTTONS - 1; b >= 0; b--) begin
      code_b       = code_of(action_map_r, b);
      emit_mask[b] = rising[b] && (code_b > {1'b0, DIR_NEXT});
      if (levels[b] && (code_b == {1'b0, DIR_PREV} || code_b == {1'b0, DIR_NEXT})) begin
        btn_dir = code_b[1:0];
      end
    end
  end

  assign y_ext  = {in_r.stick_y[15], in_r.stick_y};
  assign dz_pos = $signed({2'b00, deadzone_r});

  always_comb begin
    if (btn_dir != DIR_NONE) begin
      sample_dir = btn_dir;
    end else if (y_ext > dz_pos) begin
      sample_dir = DIR_NEXT;
    end else if (y_ext < -dz_pos) begin
      sample_dir = DIR_PREV;
    end else begin
      sample_dir = DIR_NONE;
    end
  end

  assign time_sum = {1'b0, held_time_r} + {13'd0, in_r.tick_time};
  assign time_sat = time_sum[32] ? '1 : time_sum[31:0];

  assign out_free = !out_valid_r || out_ready;
  assign cur_bit  = mask_r[idx_r];
  assign above    = (mask_r >> idx_r) >> 1;
  assign code_cur = code_of(action_map_r, 32'(idx_r));

  assign sts.op         = in_r.operation;
  assign sts.slot_ok    = slot_ok;
  assign sts.mask_empty = (mask_r == '0);
  assign sts.fire       = fire_r;
  assign sts.out_free   = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      action_map_r      <= ACTION_MAP_RST;
      deadzone_r        <= DEADZONE_RST;
      initial_delay_r   <= INITIAL_DELAY_RST;
      repeat_interval_r <= REPEAT_INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTION_MAP:      action_map_r      <= cfg_data[MAP_W-1:0];
        REG_DEADZONE:        deadzone_r        <= cfg_data[14:0];
        REG_INITIAL_DELAY:   initial_delay_r   <= cfg_data[31:0];
        REG_REPEAT_INTERVAL: repeat_interval_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PADS; p++) begin
        pressed_r[p] <= '0;
      end
      mask_r      <= '0;
      idx_r       <= '0;
      tick_dir_r  <= DIR_NONE;
      hold_dir_r  <= DIR_NONE;
      held_time_r <= '0;
      repeating_r <= 1'b0;
      fire_r      <= 1'b0;
      fire_dir_r  <= DIR_NONE;
    end else if (cmd.exec) begin
      if (in_r.operation == OP_TICK) begin
        tick_dir_r <= DIR_NONE;
        fire_dir_r <= tick_dir_r;
        if (tick_dir_r == DIR_NONE) begin
          hold_dir_r  <= DIR_NONE;
          held_time_r <= '0;
          repeating_r <= 1'b0;
          fire_r      <= 1'b0;
        end else if (tick_dir_r != hold_dir_r) begin
          hold_dir_r  <= tick_dir_r;
          held_time_r <= '0;
          repeating_r <= 1'b0;
          fire_r      <= 1'b1;
        end else if (!repeating_r) begin
          if (time_sat >= initial_delay_r) begin
            repeating_r <= 1'b1;
            held_time_r <= '0;
            fire_r      <= 1'b1;
          end else begin
            held_time_r <= time_sat;
            fire_r      <= 1'b0;
          end
        end else if (time_sat >= repeat_interval_r) begin
          held_time_r <= '0;
          fire_r      <= 1'b1;
        end else begin
          held_time_r <= time_sat;
          fire_r      <= 1'b0;
        end
      end else if (slot_ok) begin
        pressed_r[pad] <= (in_r.operation == OP_SAMPLE) ? levels : '0;
        if (in_r.operation == OP_REMOVE) begin
          hold_dir_r <= DIR_NONE;
        end
        if (in_r.operation == OP_SAMPLE) begin
          mask_r <= emit_mask;
          idx_r  <= '0;
          if (tick_dir_r == DIR_NONE) begin
            tick_dir_r <= sample_dir;
          end
        end
      end
    end else if (cmd.step) begin
      // Walk the pending mask one button a cycle; a set bit waits for the output.
      if (!cur_bit) begin
        idx_r <= idx_r + 1'b1;
      end else if (out_free) begin
        mask_r[idx_r] <= 1'b0;
        idx_r         <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.step && cur_bit && out_free) || cmd.emit_tick) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_tick) begin
      out_r.action <= {1'b0, fire_dir_r};
      out_r.last   <= 1'b1;
    end else if (cmd.step && cur_bit && out_free) begin
      out_r.action <= code_cur;
      out_r.last   <= (above == '0);
    end
  end

endmodule

[design/pad_button_events_with_auto_repeat.sv]
`timescale 1ns / 1ps

// Turns polled pad samples into action words with typematic auto-repeat on the
// prev/next direction. A pad sample is loaded and executed, then walks the
// pending press mask one button position per cycle, up to and including the
// highest newly pressed button that emits; the walk holds at a set bit while
// the output is busy. Connect and removal words are loaded and executed; an
// end of tick then passes the tick-out state. Words are taken only when idle.
// A result that waits on out_ready holds the walk at the next emitting button,
// or holds the tick until its word can be loaded. Each sample or tick word
// yields zero or more result words, and the final one of them carries last set.
module pad_button_events_with_auto_repeat import pbe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pbe_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pbe_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  pbe_cmd_t cmd;
  pbe_sts_t sts;

  pbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pbe_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import pbe_pkg::*;

  localparam int SETTLE = 30;      // margin for a sample to walk its whole press mask
  localparam int QUIET_LIMIT = 3000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  pbe_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pbe_out_t out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  pad_button_events_with_auto_repeat dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block's configuration and typematic state.
  logic [MAP_W-1:0] act_map = ACTION_MAP_RST;
  logic [14:0]      dzone = DEADZONE_RST;
  logic [31:0]      init_delay = INITIAL_DELAY_RST;
  logic [31:0]      rep_interval = REPEAT_INTERVAL_RST;
  logic [20:0]      pressed_levels [PADS];
  logic [1:0]       tick_dir = DIR_NONE;
  logic [1:0]       hold_dir = DIR_NONE;
  logic [31:0]      held_us = '0;
  logic             repeating = 1'b0;

  pbe_out_t pending_actions [$];
  pbe_out_t want;
  int       n_fail = 0;
  int       quiet_cycles = 0;
  bit       gap_en = 1'b1;
  bit       stall_en = 1'b1;

  initial begin
    for (int s = 0; s < PADS; s++) pressed_levels[s] = '0;
  end

  task automatic predict_word(input pbe_in_t w);
    logic [20:0] rising;
    logic [2:0]  c;
    logic [1:0]  dir;
    logic [32:0] sum;
    logic        fire;
    pbe_out_t    r;
    int          y, dz, b, top;
    fire = 1'b0;
    if (w.operation == OP_TICK) begin
      dir = tick_dir;
      tick_dir = DIR_NONE;
      if (dir == DIR_NONE) begin
        hold_dir = DIR_NONE;
        held_us = '0;
        repeating = 1'b0;
      end else if (dir != hold_dir) begin
        hold_dir = dir;
        held_us = '0;
        repeating = 1'b0;
        fire = 1'b1;
      end else begin
        sum = {1'b0, held_us} + {13'd0, w.tick_time};
        held_us = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (!repeating) begin
          if (held_us >= init_delay) begin
            repeating = 1'b1;
            held_us = '0;
            fire = 1'b1;
          end
        end else if (held_us >= rep_interval) begin
          held_us = '0;
          fire = 1'b1;
        end
      end
      if (fire) begin
        r.action = {1'b0, dir};
        r.last = 1'b1;
        pending_actions.push_back(r);
      end
    end else if (int'(w.pad_slot) < PADS) begin
      case (w.operation)
        OP_CONNECT: pressed_levels[w.pad_slot] = '0;
        OP_REMOVE: begin
          pressed_levels[w.pad_slot] = '0;
          hold_dir = DIR_NONE;
        end
        default: begin
          rising = w.buttons & ~pressed_levels[w.pad_slot];
          pressed_levels[w.pad_slot] = w.buttons;
          top = -1;
          for (b = 0; b < BUTTONS; b++) begin
            c = act_map[3*b +: 3];
            if (rising[b] && c != 3'd0 && c != {1'b0, DIR_PREV} && c != {1'b0, DIR_NEXT})
              top = b;
          end
          for (b = 0; b <= top; b++) begin
            c = act_map[3*b +: 3];
            if (rising[b] && c != 3'd0 && c != {1'b0, DIR_PREV} && c != {1'b0, DIR_NEXT}) begin
              r.action = c;
              r.last = (b == top);
              pending_actions.push_back(r);
            end
          end
          if (tick_dir == DIR_NONE) begin
            dir = DIR_NONE;
            for (b = 0; b < BUTTONS; b++) begin
              c = act_map[3*b +: 3];
              if (dir == DIR_NONE && w.buttons[b] &&
                  (c == {1'b0, DIR_PREV} || c == {1'b0, DIR_NEXT}))
                dir = c[1:0];
            end
            if (dir == DIR_NONE) begin
              y = w.stick_y;
              dz = int'(dzone);
              if (y > dz) dir = DIR_NEXT;
              else if (y < -dz) dir = DIR_PREV;
            end
            tick_dir = dir;
          end
        end
      endcase
    end
  endtask

  function automatic pbe_in_t make_word(input logic [1:0] op, input int slot,
                                        input logic [20:0] levels, input int y,
                                        input int unsigned tt);
    pbe_in_t w;
    w.operation = op;
    w.pad_slot = SLOT_W'(slot);
    w.buttons = levels;
    w.stick_y = 16'(y);
    w.tick_time = 20'(tt);
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input pbe_in_t w);
    if (gap_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(w);
    @(negedge clk);
  endtask

  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (pending_actions.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_ACTION_MAP:      act_map = val;
      REG_DEADZONE:        dzone = val[14:0];
      REG_INITIAL_DELAY:   init_delay = val[31:0];
      REG_REPEAT_INTERVAL: rep_interval = val[31:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [MAP_W-1:0] m, input int unsigned dz,
                           input logic [31:0] dly, input logic [31:0] ivl);
    write_reg(REG_ACTION_MAP, m);
    write_reg(REG_DEADZONE, CFG_W'(dz));
    write_reg(REG_INITIAL_DELAY, CFG_W'(dly));
    write_reg(REG_REPEAT_INTERVAL, CFG_W'(ivl));
  endtask

  task automatic test_default_config();
    send_word(make_word(OP_SAMPLE, 0, 21'h1FFFFF, 0, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 0));
    send_word(make_word(OP_SAMPLE, 1, 0, 32767, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 1000000));
    send_word(make_word(OP_SAMPLE, 2, 0, -32768, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 500000));
    // Exactly on the deadzone does not count as a direction.
    send_word(make_word(OP_SAMPLE, 3, 0, 16384, 0));
    send_word(make_word(OP_SAMPLE, 3, 0, -16384, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 0));
    send_word(make_word(OP_SAMPLE, 0, 0, -16385, 0));
    send_word(make_word(OP_TICK, 3, 21'h1FFFFF, 0, 1000000));
    wait_until_idle();
  endtask

  task automatic test_press_events();
    logic [MAP_W-1:0] m;
    for (int b = 0; b < BUTTONS; b++) m[3*b +: 3] = 3'(3 + b % 5);
    write_reg(REG_ACTION_MAP, CFG_W'(m));
    send_word(make_word(OP_SAMPLE, 0, 21'h1FFFFF, 0, 0));
    send_word(make_word(OP_SAMPLE, 0, 21'h1FFFFF, 0, 0));
    send_word(make_word(OP_CONNECT, 0, 0, 0, 0));
    send_word(make_word(OP_SAMPLE, 0, 21'h1FFFFF, 0, 0));
    send_word(make_word(OP_SAMPLE, 3, 21'h100000, 0, 0));
    send_word(make_word(OP_SAMPLE, 3, 0, 0, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 0));
    wait_until_idle();
    // Buttons mapped to none, prev or next give no word of their own.
    m[2:0] = {1'b0, DIR_PREV};
    m[5:3] = {1'b0, DIR_NEXT};
    m[8:6] = 3'd0;
    write_reg(REG_ACTION_MAP, CFG_W'(m));
    send_word(make_word(OP_SAMPLE, 2, 21'h1FFFFF, 0, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 0));
    wait_until_idle();
  endtask

  task automatic test_typematic_timing();
    logic [MAP_W-1:0] m;
    for (int b = 0; b < BUTTONS; b++) m[3*b +: 3] = 3'(3 + b % 5);
    m[2:0] = {1'b0, DIR_PREV};
    m[5:3] = {1'b0, DIR_NEXT};
    write_all(m, 0, 32'd100, 32'd30);
    send_word(make_word(OP_SAMPLE, 0, 0, 1, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 0));
    send_word(make_word(OP_SAMPLE, 0, 0, 1, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 60));
    send_word(make_word(OP_SAMPLE, 0, 0, 1, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 50));
    send_word(make_word(OP_SAMPLE, 0, 0, 1, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 30));
    send_word(make_word(OP_SAMPLE, 0, 0, 1, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 10));
    // A prev button outranks the stick.
    send_word(make_word(OP_SAMPLE, 0, 21'h000001, 1, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 5));
    send_word(make_word(OP_SAMPLE, 0, 0, -1, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 0));
    wait_until_idle();
    write_reg(REG_INITIAL_DELAY, '0);
    write_reg(REG_REPEAT_INTERVAL, '0);
    repeat (3) begin
      send_word(make_word(OP_SAMPLE, 1, 0, 1, 0));
      send_word(make_word(OP_TICK, 0, 0, 0, 0));
    end
    wait_until_idle();
  endtask

  task automatic test_direction_priority();
    logic [MAP_W-1:0] m;
    m = '0;
    m[11:9] = {1'b0, DIR_PREV};
    m[17:15] = {1'b0, DIR_NEXT};
    m[23:21] = 3'd4;
    write_reg(REG_ACTION_MAP, CFG_W'(m));
    write_reg(REG_DEADZONE, CFG_W'(100));
    send_word(make_word(OP_SAMPLE, 0, 0, 0, 0));
    send_word(make_word(OP_SAMPLE, 1, 21'h0000A8, 32767, 0));
    send_word(make_word(OP_SAMPLE, 2, 0, 32767, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 0));
    send_word(make_word(OP_SAMPLE, 0, 0, 32767, 0));
    send_word(make_word(OP_SAMPLE, 1, 21'h000008, 0, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 0));
    wait_until_idle();
  endtask

  task automatic test_pad_hotplug();
    write_reg(REG_INITIAL_DELAY, CFG_W'(1000));
    write_reg(REG_REPEAT_INTERVAL, CFG_W'(1000));
    send_word(make_word(OP_SAMPLE, 1, 0, 32767, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 0));
    send_word(make_word(OP_SAMPLE, 1, 0, 32767, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 10));
    // Removing a pad drops the held direction, so the next tick fires at once.
    send_word(make_word(OP_REMOVE, 1, 0, 0, 0));
    send_word(make_word(OP_SAMPLE, 1, 0, 32767, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 10));
    send_word(make_word(OP_SAMPLE, 2, 21'h000080, 0, 0));
    send_word(make_word(OP_CONNECT, 2, 0, 0, 0));
    send_word(make_word(OP_SAMPLE, 2, 21'h000080, 0, 0));
    send_word(make_word(OP_REMOVE, 2, 0, 0, 0));
    send_word(make_word(OP_SAMPLE, 2, 21'h000080, 0, 0));
    send_word(make_word(OP_TICK, 0, 0, 0, 0));
    wait_until_idle();
  endtask

  task automatic test_long_hold();
    // Delays of several seconds build up over many full-length ticks.
    write_all('0, 0, 32'd3_500_000, 32'd2_000_000);
    repeat (8) begin
      send_word(make_word(OP_SAMPLE, 0, 0, 1, 0));
      send_word(make_word(OP_TICK, 0, 0, 0, 1000000));
    end
    wait_until_idle();
  endtask

  task automatic test_random_traffic();
    logic [20:0] levels [PADS];
    int mode, y, s, p, start, n_words;
    int unsigned tt;
    bit paused;
    n_words = 0;
    mode = 0;
    paused = 1'b0;
    for (s = 0; s < PADS; s++) levels[s] = '0;
    for (p = 0; p < 6; p++) begin
      wait_until_idle();
      case (p)
        0: write_all(CFG_W'({$urandom, $urandom}), 0, '0, '0);
        1: write_all('1, 32767, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: write_all('0, $urandom_range(0, 20000), $urandom_range(0, 150000),
                     $urandom_range(0, 60000));
        default: write_all(CFG_W'({$urandom, $urandom}), $urandom_range(0, 32767),
                           $urandom_range(0, 150000), $urandom_range(0, 60000));
      endcase
      if (p == 5) begin
        gap_en = 1'b0;
        stall_en = 1'b0;
      end
      start = n_words;
      while (n_words - start < 58) begin
        if ($urandom_range(0, 5) == 0) mode = $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) begin
          send_word(make_word(2'($urandom_range(0, 3)), $urandom_range(0, 3),
                              21'($urandom), int'($urandom_range(0, 65535)) - 32768,
                              $urandom_range(0, 1000000)));
          n_words++;
        end else begin
          for (s = 0; s < PADS; s++) begin
            if ($urandom_range(0, 3) != 0) begin
              case ($urandom_range(0, 7))
                0: levels[s] = '0;
                1: levels[s] = '1;
                default: levels[s] = levels[s] ^ 21'(1 << $urandom_range(0, 20));
              endcase
              case (mode)
                1: y = -32768 + int'($urandom_range(0, 12000));
                2: y = 32767 - int'($urandom_range(0, 12000));
                default: y = $urandom_range(0, 1) ? int'($urandom_range(0, 4000)) - 2000
                                                  : int'($urandom_range(0, 65535)) - 32768;
              endcase
              send_word(make_word(OP_SAMPLE, s, levels[s], y, $urandom_range(0, 1000000)));
              n_words++;
            end
          end
          tt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1000000)
                                           : $urandom_range(0, 40000);
          send_word(make_word(OP_TICK, $urandom_range(0, 3), 21'($urandom),
                              int'($urandom_range(0, 65535)) - 32768, tt));
          n_words++;
        end
        // Let the result side drain completely once in mid traffic.
        if (p == 2 && !paused && n_words - start >= 29) begin
          paused = 1'b1;
          wait_until_idle();
        end
      end
    end
    wait_until_idle();
  endtask

  always begin
    @(negedge clk);
    if (stall_en && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (pending_actions.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("unexpected result word: action=%0d last=%0d", out_data.action,
                   out_data.last);
      end else begin
        want = pending_actions.pop_front();
        if (out_data.action !== want.action || out_data.last !== want.last) begin
          n_fail++;
          if (n_fail <= 10)
            $display("result mismatch: action exp=%0d got=%0d, last exp=%0d got=%0d",
                     want.action, out_data.action, want.last, out_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_default_config();
    test_press_events();
    test_typematic_timing();
    test_direction_priority();
    test_pad_hotplug();
    test_long_hold();
    test_random_traffic();
    if (pending_actions.size() != 0) begin
      n_fail++;
      $display("%0d expected result words never arrived", pending_actions.size());
    end
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
